// ===== hw/rtl/bec5_pkg.sv =====
// shared types, constants and helpers for the 5x5 cross erosion block
// no dependencies; imported by every other file of the block

package bec5_pkg;

   // frame limits and derived widths
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int DIM_W      = 12;
   localparam int POS_W      = $clog2(MAX_WIDTH);
   localparam int PEND_W     = DIM_W + 1;

   // line store holds the flags of the four rows above the input row
   localparam int LS_DEPTH = MAX_WIDTH;
   localparam int LS_AW    = $clog2(LS_DEPTH);
   localparam int LS_DW    = 4;
   localparam int WIN_W    = LS_DW + 1;
   localparam logic [WIN_W-1:0] ALL_SET = '1;

   // pixel values
   localparam int PIX_W = 8;
   localparam logic [PIX_W-1:0] EMPTY = 8'd0;
   localparam logic [PIX_W-1:0] FULL  = 8'd255;

   // register file
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;
   localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;

   // result queue
   localparam int FIFO_DEPTH = 3;
   localparam int FIFO_AW    = 2;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             restart;
   } cfg_type;

   typedef struct packed {
      logic             en;
      logic [LS_AW-1:0] addr;
      logic [LS_DW-1:0] data;
   } wr_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_pixel;
      logic             frame_end;
   } res_type;

   // zero acts as one, large values saturate
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] limit);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = {{(DIM_W-1){1'b0}}, 1'b1};
      else if (v > limit) r = limit;
      return r;
   endfunction

endpackage

// ===== hw/rtl/bec5_intf.sv =====
// valid/ready channel interfaces for the pixel input and the result output
// depends on bec5_pkg

interface bec5_req_if;
   import bec5_pkg::*;
   logic             valid;
   logic             ready;
   logic             op;
   logic [PIX_W-1:0] pixel;

   modport source (output valid, output op, output pixel, input ready);
   modport sink (input valid, input op, input pixel, output ready);
endinterface

interface bec5_rsp_if;
   import bec5_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_pixel;
   logic             frame_end;

   modport source (output valid, output out_pixel, output frame_end, input ready);
   modport sink (input valid, input out_pixel, input frame_end, output ready);
endinterface

// ===== hw/rtl/bec5_line_ram.sv =====
// line store: one column of four row flags per entry, one write and one read port
// depends on bec5_pkg; read data is registered

module bec5_line_ram (
   input  logic                      clock,
   input  bec5_pkg::wr_type          wr,
   input  logic                      rd_en,
   input  logic [bec5_pkg::LS_AW-1:0] rd_addr,
   output logic [bec5_pkg::LS_DW-1:0] rd_data_ff
);
   import bec5_pkg::*;

   logic [LS_DW-1:0] mem [LS_DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/bec5_core.sv =====
// erosion datapath: column build, window registers, output position and pending count
// depends on bec5_pkg; pairs with bec5_line_ram for the read-modify-write of a column

module bec5_core (
   input  logic                       clock,
   input  logic                       reset,
   input  bec5_pkg::cfg_type          cfg,
   input  logic                       acc,
   input  logic                       op,
   input  logic [bec5_pkg::PIX_W-1:0] pixel,
   input  logic [bec5_pkg::LS_DW-1:0] rd_data,
   output logic [bec5_pkg::LS_AW-1:0] rd_addr,
   output bec5_pkg::wr_type           wr,
   output logic                       res_valid,
   output bec5_pkg::res_type          res,
   output logic                       busy
);
   import bec5_pkg::*;

   // stage 1 item
   logic              s1_v_ff;
   logic              s1_op_ff;
   logic              s1_flag_ff;
   logic [LS_AW-1:0]  s1_addr_ff;
   logic              s1_fwd_ff;
   logic [LS_DW-1:0]  hold_ff;

   // frame state
   logic [POS_W-1:0]  in_col_ff, in_col_in;
   logic [WIN_W-1:0]  center_ff, center_in;
   logic [WIN_W-1:0]  cd0_ff, cd0_in;
   logic [WIN_W-1:0]  cd1_ff, cd1_in;
   logic [POS_W-1:0]  out_row_ff, out_row_in;
   logic [POS_W-1:0]  out_col_ff, out_col_in;
   logic [PEND_W-1:0] pending_ff, pending_in;

   logic [PEND_W-1:0] thr;
   logic [LS_DW-1:0]  prev4;
   logic [WIN_W-1:0]  col_bits;
   logic [WIN_W-1:0]  center_new;
   logic              on_border;
   logic              is_last;
   logic              emit;
   logic [PIX_W-1:0]  value;

   assign thr     = {cfg.width, 1'b0} + PEND_W'(2);
   assign rd_addr = in_col_ff;
   assign busy    = s1_v_ff;

   // next input column, advanced at accept time so the read address is ready
   always_comb begin
      in_col_in = in_col_ff;
      if (acc && op == OP_PIXEL) begin
         if (({1'b0, in_col_ff} + DIM_W'(1)) >= cfg.width) in_col_in = '0;
         else in_col_in = in_col_ff + POS_W'(1);
      end
   end

   // column of five flags, forwarded when the previous item wrote the same entry
   assign prev4      = s1_fwd_ff ? hold_ff : rd_data;
   assign col_bits   = {prev4, s1_flag_ff};
   assign center_new = {center_ff[WIN_W-2:0], col_bits[2]};

   assign wr.en   = s1_v_ff && s1_op_ff == OP_PIXEL;
   assign wr.addr = s1_addr_ff;
   assign wr.data = col_bits[LS_DW-1:0];

   // border and last-pixel tests on the output position
   assign on_border = (out_row_ff < POS_W'(2)) ||
                      (({1'b0, out_row_ff} + DIM_W'(2)) >= cfg.height) ||
                      (out_col_ff < POS_W'(2)) ||
                      (({1'b0, out_col_ff} + DIM_W'(2)) >= cfg.width);
   assign is_last = (({1'b0, out_row_ff} + DIM_W'(1)) == cfg.height) &&
                    (({1'b0, out_col_ff} + DIM_W'(1)) == cfg.width);

   // result decision and state update of stage 1
   always_comb begin
      emit       = 1'b0;
      value      = FULL;
      center_in  = center_ff;
      cd0_in     = cd0_ff;
      cd1_in     = cd1_ff;
      pending_in = pending_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (s1_v_ff) begin
         if (s1_op_ff == OP_PIXEL) begin
            center_in = center_new;
            cd0_in    = col_bits;
            cd1_in    = cd0_ff;
            if (pending_ff >= thr) begin
               emit  = 1'b1;
               value = (on_border || (cd1_ff == ALL_SET && center_new == ALL_SET)) ?
                       FULL : EMPTY;
            end else begin
               pending_in = pending_ff + PEND_W'(1);
            end
         end else if (pending_ff != '0 && on_border) begin
            emit       = 1'b1;
            pending_in = pending_ff - PEND_W'(1);
         end
         // advance the output position
         if (emit) begin
            if (({1'b0, out_col_ff} + DIM_W'(1)) >= cfg.width) begin
               out_col_in = '0;
               if (({1'b0, out_row_ff} + DIM_W'(1)) >= cfg.height) out_row_in = '0;
               else out_row_in = out_row_ff + POS_W'(1);
            end else begin
               out_col_in = out_col_ff + POS_W'(1);
            end
         end
      end
   end

   assign res_valid     = emit;
   assign res.out_pixel = value;
   assign res.frame_end = is_last;

   // control and frame state
   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         s1_v_ff    <= 1'b0;
         in_col_ff  <= '0;
         center_ff  <= '0;
         cd0_ff     <= '0;
         cd1_ff     <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         pending_ff <= '0;
      end else begin
         s1_v_ff    <= acc;
         in_col_ff  <= in_col_in;
         center_ff  <= center_in;
         cd0_ff     <= cd0_in;
         cd1_ff     <= cd1_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         pending_ff <= pending_in;
      end
   end

   // stage 1 payload and forwarding data
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_op_ff   <= op;
         s1_flag_ff <= |pixel;
         s1_addr_ff <= in_col_ff;
         s1_fwd_ff  <= wr.en && (wr.addr == in_col_ff);
      end
      if (wr.en) begin
         hold_ff <= wr.data;
      end
   end

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= thr)
      else $error("pending count above the output delay");

   a_flush_full: assert property (@(posedge clock) disable iff (reset)
      res_valid && s1_op_ff == OP_FLUSH |-> res.out_pixel == FULL)
      else $error("flush beat gave a non-full pixel");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.frame_end |=> out_row_ff == '0 && out_col_ff == '0)
      else $error("output position did not wrap after frame end");

endmodule

// ===== hw/rtl/bec5_out_fifo.sv =====
// three-entry result queue between the datapath and the output channel
// depends on bec5_pkg and bec5_intf

module bec5_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bec5_pkg::res_type din,
   input  logic              inflight,
   output logic              room,
   bec5_rsp_if.source        rsp
);
   import bec5_pkg::*;

   res_type               mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW-1:0]    count_ff, count_in;
   logic                  pop;

   assign pop = rsp.valid && rsp.ready;

   // one slot per item that may still produce a result
   assign room = ({1'b0, count_ff} + {{FIFO_AW{1'b0}}, inflight}) < (FIFO_AW + 1)'(FIFO_DEPTH);

   assign rsp.valid     = count_ff != '0;
   assign rsp.out_pixel = mem[rd_ptr_ff].out_pixel;
   assign rsp.frame_end = mem[rd_ptr_ff].frame_end;

   // pointer and count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + FIFO_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + FIFO_AW'(1);
      end
      if (push && !pop) count_in = count_ff + FIFO_AW'(1);
      else if (pop && !push) count_in = count_ff - FIFO_AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= din;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff < FIFO_AW'(FIFO_DEPTH))
      else $error("result beat pushed into a full queue");

endmodule

// ===== hw/rtl/binary_erosion_cross_5x5.sv =====
// binary erosion with a 5x5 cross, one pixel beat per clock in raster order
// throughput: one input beat every cycle while the result queue has room
// output path: a result is registered in stage 1 and then held in the result queue before rsp can take it;
// it is caused 2*frame_width+2 pixels later
// reset: synchronous, clears positions, windows, pending count and queue;
// width 640, height 480; line store contents stay undefined until written

module binary_erosion_cross_5x5 (
   input  logic                        clock,
   input  logic                        reset,
   bec5_req_if.sink                    req,
   bec5_rsp_if.source                  rsp,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bec5_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [bec5_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [bec5_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import bec5_pkg::*;

   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic             csr_wr;
   cfg_type          cfg;
   logic             acc;
   logic             room;
   logic             busy;
   logic [LS_AW-1:0] rd_addr;
   logic [LS_DW-1:0] rd_data;
   wr_type           wr;
   logic             res_valid;
   res_type          res;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_WIDTH: width_ff <= clamp_dim(csr_pwdata[DIM_W-1:0], DIM_W'(MAX_WIDTH));
            REG_HEIGHT: height_ff <= clamp_dim(csr_pwdata[DIM_W-1:0], DIM_W'(MAX_HEIGHT));
            default: width_ff <= width_ff;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_paddr[2])
         REG_WIDTH: csr_prdata = {{(CSR_DW - DIM_W){1'b0}}, width_ff};
         REG_HEIGHT: csr_prdata = {{(CSR_DW - DIM_W){1'b0}}, height_ff};
         default: csr_prdata = '0;
      endcase
   end

   // any register write restarts the frame
   assign cfg.width   = width_ff;
   assign cfg.height  = height_ff;
   assign cfg.restart = csr_wr;

   // input handshake
   assign req.ready = room;
   assign acc       = req.valid && req.ready;

   bec5_line_ram u_line_ram (
      .clock      (clock),
      .wr         (wr),
      .rd_en      (acc),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   bec5_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .acc       (acc),
      .op        (req.op),
      .pixel     (req.pixel),
      .rd_data   (rd_data),
      .rd_addr   (rd_addr),
      .wr        (wr),
      .res_valid (res_valid),
      .res       (res),
      .busy      (busy)
   );

   bec5_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (res_valid),
      .din      (res),
      .inflight (busy),
      .room     (room),
      .rsp      (rsp)
   );

endmodule
